### sv/sld_pkg.sv
`default_nettype none

package sld_pkg;

  // Field widths of the transactions on both channels.
  localparam int POS_W     = 5;
  localparam int DATA_W    = 32;
  localparam int STATUS_W  = 2;
  localparam int CNT_OUT_W = 5;

  // Default list capacity.
  localparam int DEPTH_DEFAULT = 16;

  // Operation codes.
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

  // Request transaction.
  typedef struct packed {
    logic                     cmd;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } sld_req_t;

  // Response transaction.
  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] removed_value;
    logic [CNT_OUT_W-1:0]     count_after;
  } sld_rsp_t;

endpackage

`default_nettype wire

### sv/sld_chan_if.sv
`default_nettype none

// Valid/ready channel carrying one payload per transaction.
interface sld_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### sv/sld_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module sld_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### sv/sequential_list_insert_delete_unit.sv
`default_nettype none

// Positional list engine holding up to DEPTH signed 32-bit entries in order.
// Requests arrive on in_ch (cmd, 1-based position, value); each request gives
// exactly one response on out_ch (status, removed value, count after).
// An insert at position p moves entries p..count up one place and stores the
// value; a delete at p returns entry p and moves the later entries down.
// The entries sit in a single-port-write, registered-read RAM and one entry
// is moved per cycle through that RAM. With count the fill level before the
// request, an insert reads and moves entries count down to p, then writes the
// value at p; a delete reads entry p, then moves entries p+1..count down; a
// request whose status is not ok goes straight to the response. The response
// turns valid in the same cycle as the engine returns to idle and can accept
// the next request.
// in_ch.ready is high only while the engine is idle; one request at a time.
// The response sits in an output register: the engine takes the next request
// while a response still waits, and stalls at the end of that request until
// the receiver has taken the earlier one.
// Reset empties the list at once (the fill count goes to zero) and drops any
// pending response; the RAM contents are not cleared.
module sequential_list_insert_delete_unit #(
  parameter int DEPTH = sld_pkg::DEPTH_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  sld_chan_if.sink   in_ch,
  sld_chan_if.source out_ch
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = ((CW > sld_pkg::POS_W) ? CW : sld_pkg::POS_W) + 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SHIFT = 2'd1;
  localparam logic [1:0] S_FIN   = 2'd2;
  localparam logic [1:0] S_RESP  = 2'd3;

  logic [1:0]    state;
  logic [CW-1:0] count;
  logic          ins;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] rd_left;
  logic          first;
  logic          pend;
  logic          pend_first;
  logic [AW-1:0] pend_addr;
  logic [AW-1:0] slot;
  logic signed [sld_pkg::DATA_W-1:0] val_q;
  logic signed [sld_pkg::DATA_W-1:0] taken;
  logic [sld_pkg::STATUS_W-1:0]      status_q;

  logic                     out_valid;
  sld_pkg::sld_rsp_t        out_q;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [sld_pkg::DATA_W-1:0]  ram_wdata;
  logic [sld_pkg::DATA_W-1:0]  ram_rdata;

  logic                         accept;
  logic [EW-1:0]                pos_e;
  logic [EW-1:0]                cnt_e;
  logic                         bad_pos;
  logic                         is_full;
  logic [sld_pkg::STATUS_W-1:0] req_status;
  logic                         out_free;

  assign in_ch.ready    = (state == S_IDLE);
  assign accept         = in_ch.valid && in_ch.ready;
  assign out_ch.valid   = out_valid;
  assign out_ch.payload = out_q;
  assign out_free       = !out_valid || out_ch.ready;

  // Position and capacity checks on the incoming request.
  always_comb begin
    pos_e   = EW'(in_ch.payload.position);
    cnt_e   = EW'(count);
    bad_pos = (pos_e == '0) || (pos_e > cnt_e + EW'(1));
    is_full = (count == CW'(DEPTH));
    if (in_ch.payload.cmd == sld_pkg::CMD_INSERT) begin
      if (bad_pos) begin
        req_status = sld_pkg::ST_BADPOS;
      end else if (is_full) begin
        req_status = sld_pkg::ST_FULL;
      end else begin
        req_status = sld_pkg::ST_OK;
      end
    end else begin
      if (bad_pos) begin
        req_status = sld_pkg::ST_BADPOS;
      end else if (count == '0) begin
        req_status = sld_pkg::ST_EMPTY;
      end else if (pos_e > cnt_e) begin
        req_status = sld_pkg::ST_BADPOS;
      end else begin
        req_status = sld_pkg::ST_OK;
      end
    end
  end

  // The single RAM write port: shifted entries, then the inserted value.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pend_addr;
    ram_wdata = ram_rdata;
    unique case (state)
      S_SHIFT: begin
        if (pend) begin
          if (ins) begin
            ram_we    = 1'b1;
            ram_waddr = pend_addr + AW'(1);
          end else if (!pend_first) begin
            ram_we    = 1'b1;
            ram_waddr = pend_addr - AW'(1);
          end
        end
      end
      S_FIN: begin
        ram_we    = 1'b1;
        ram_waddr = slot;
        ram_wdata = val_q;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  sld_ram #(
    .WIDTH (sld_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_ptr),
    .rdata (ram_rdata)
  );

  // Sequencer: check, move entries one per cycle, write the value, respond.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      pend       <= 1'b0;
      pend_first <= 1'b0;
      first      <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            ins      <= (in_ch.payload.cmd == sld_pkg::CMD_INSERT);
            val_q    <= in_ch.payload.value;
            status_q <= req_status;
            taken    <= '0;
            slot     <= AW'(pos_e - EW'(1));
            rd_left  <= CW'(cnt_e - pos_e + EW'(1));
            first    <= 1'b1;
            pend     <= 1'b0;
            if (in_ch.payload.cmd == sld_pkg::CMD_INSERT) begin
              rd_ptr <= AW'(cnt_e - EW'(1));
            end else begin
              rd_ptr <= AW'(pos_e - EW'(1));
            end
            if (req_status == sld_pkg::ST_OK) begin
              state <= S_SHIFT;
              if (in_ch.payload.cmd == sld_pkg::CMD_INSERT) begin
                count <= count + CW'(1);
              end else begin
                count <= count - CW'(1);
              end
            end else begin
              state <= S_RESP;
            end
          end
        end
        S_SHIFT: begin
          if (pend && !ins && pend_first) begin
            taken <= ram_rdata;
          end
          if (rd_left != '0) begin
            pend       <= 1'b1;
            pend_first <= first;
            pend_addr  <= rd_ptr;
            first      <= 1'b0;
            rd_left    <= rd_left - CW'(1);
            if (ins) begin
              rd_ptr <= rd_ptr - AW'(1);
            end else begin
              rd_ptr <= rd_ptr + AW'(1);
            end
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              state <= ins ? S_FIN : S_RESP;
            end
          end
        end
        S_FIN: begin
          state <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register holding the response until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_RESP && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RESP && out_free) begin
      out_q.status        <= status_q;
      out_q.removed_value <= taken;
      out_q.count_after   <= sld_pkg::CNT_OUT_W'(count);
    end
  end

  // The fill count never exceeds the capacity.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("fill count above capacity");

  // An accepted insert with ok status grows the list by exactly one entry.
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && req_status == sld_pkg::ST_OK &&
     in_ch.payload.cmd == sld_pkg::CMD_INSERT) |=> (count == $past(count) + CW'(1)))
    else $error("insert did not grow the list by one");

  // The RAM is written only while entries are moved or the value is stored.
  a_write_window: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_SHIFT || state == S_FIN))
    else $error("RAM written outside the move sequence");

  // A new response is loaded only from the response state.
  a_resp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_RESP))
    else $error("response raised outside the response state");

endmodule

`default_nettype wire
